>>> rtl/olab_pkg.sv
// Shared types and constants for the linear RGB to Oklab converter.
`default_nettype none
package olab_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 20;
  localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  // Coefficient product, rounded divide by 10^10 = 2^10 * 5^10
  localparam int COEF_W  = 35;
  localparam int PROD_W  = FIELD_W + COEF_W;
  localparam logic [PROD_W-1:0] COEF_HALF = PROD_W'(64'd5000000000);
  localparam int DIV_SH  = 10;
  localparam int NSH_W   = PROD_W - DIV_SH;
  localparam int APX_SH  = 24;
  localparam int APX_W   = PROD_W - APX_SH;
  localparam int DIV_W   = 24;
  localparam logic [DIV_W-1:0] DIV_K = DIV_W'(9765625);
  localparam int RCP_W   = 32;
  localparam logic [RCP_W-1:0] RCP_K = 32'd3689348814;
  localparam int RCP_SH  = 41;
  localparam int TPR_W   = APX_W + RCP_W;
  localparam int QE_W    = TPR_W - RCP_SH;
  localparam int QD_W    = QE_W + DIV_W;
  localparam int Q_W     = QE_W + 1;
  localparam int ACC_W   = Q_W + 2;

  // Cube root
  localparam int MAG_W   = FIELD_W + 1;
  localparam int ROOT_W  = (MAG_W + 2 * FRAC_BITS + 2) / 3;
  localparam int TGT_W   = MAG_W + 2 * FRAC_BITS;
  localparam int CUBE_W  = 3 * ROOT_W + 2;

  typedef struct packed {
    logic              neg;
    logic [COEF_W-1:0] mag;
  } coef_t;

  typedef struct packed {
    logic                  neg;
    logic [MAG_W-1:0]      tmag;
    logic [ROOT_W-1:0]     y;
    logic [2*ROOT_W-1:0]   y2;
    logic [3*ROOT_W-1:0]   y3;
  } cbrt_lane_t;

  localparam coef_t TO_LMS [3][3] = '{
    '{'{1'b0, 35'd4122214708}, '{1'b0, 35'd5363325363}, '{1'b0, 35'd514459929}},
    '{'{1'b0, 35'd2119034982}, '{1'b0, 35'd6806995451}, '{1'b0, 35'd1073969566}},
    '{'{1'b0, 35'd883024619},  '{1'b0, 35'd2817188376}, '{1'b0, 35'd6299787005}}
  };

  localparam coef_t TO_LAB [3][3] = '{
    '{'{1'b0, 35'd2104542553},  '{1'b0, 35'd7936177850},  '{1'b1, 35'd40720468}},
    '{'{1'b0, 35'd19779984951}, '{1'b1, 35'd24285922050}, '{1'b0, 35'd4505937099}},
    '{'{1'b0, 35'd259040371},   '{1'b0, 35'd7827717662},  '{1'b1, 35'd8086757660}}
  };

endpackage
`default_nettype wire

>>> rtl/olab_if.sv
// Pixel channel interfaces: linear RGB in, Oklab out.
`default_nettype none
interface olab_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [olab_pkg::FIELD_W-1:0]  red_linear;
  logic signed [olab_pkg::FIELD_W-1:0]  green_linear;
  logic signed [olab_pkg::FIELD_W-1:0]  blue_linear;

  modport source (output valid, red_linear, green_linear, blue_linear, input ready);
  modport sink   (input valid, red_linear, green_linear, blue_linear, output ready);
endinterface

interface olab_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [olab_pkg::FIELD_W-1:0]  lightness;
  logic signed [olab_pkg::FIELD_W-1:0]  green_red_axis;
  logic signed [olab_pkg::FIELD_W-1:0]  blue_yellow_axis;

  modport source (output valid, lightness, green_red_axis, blue_yellow_axis, input ready);
  modport sink   (input valid, lightness, green_red_axis, blue_yellow_axis, output ready);
endinterface
`default_nettype wire

>>> rtl/olab_matmul.sv
// Six-stage 3x3 constant matrix multiply with rounded products.
`default_nettype none
module olab_matmul (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  en,
  input  wire logic                                  in_valid,
  input  wire logic signed [olab_pkg::FIELD_W-1:0]   in_vec [3],
  input  wire olab_pkg::coef_t                       coef [3][3],
  output logic                                       out_valid,
  output logic signed [olab_pkg::ACC_W-1:0]          out_vec [3]
);

  logic [5:0] v_r;

  logic [olab_pkg::PROD_W-1:0] s1_p_r   [3][3];
  logic                        s1_neg_r [3][3];
  logic [olab_pkg::NSH_W-1:0]  s2_nsh_r [3][3];
  logic [olab_pkg::APX_W-1:0]  s2_a_r   [3][3];
  logic                        s2_neg_r [3][3];
  logic [olab_pkg::TPR_W-1:0]  s3_t_r   [3][3];
  logic [olab_pkg::NSH_W-1:0]  s3_nsh_r [3][3];
  logic                        s3_neg_r [3][3];
  logic [olab_pkg::QE_W-1:0]   s4_q_r   [3][3];
  logic [olab_pkg::QD_W-1:0]   s4_qd_r  [3][3];
  logic [olab_pkg::NSH_W-1:0]  s4_nsh_r [3][3];
  logic                        s4_neg_r [3][3];
  logic signed [olab_pkg::Q_W-1:0] s5_q_r [3][3];
  logic signed [olab_pkg::ACC_W-1:0] acc_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      logic [olab_pkg::FIELD_W-1:0] absv;
      logic [olab_pkg::PROD_W-1:0]  n;
      logic [olab_pkg::QE_W-1:0]    qe;
      logic [olab_pkg::QD_W-1:0]    rem;
      logic [olab_pkg::QE_W-1:0]    q;

      always_comb begin
        absv = in_vec[j][olab_pkg::FIELD_W-1] ? olab_pkg::FIELD_W'(-in_vec[j])
                                              : olab_pkg::FIELD_W'(in_vec[j]);
        n    = s1_p_r[i][j] + olab_pkg::COEF_HALF;
        qe   = s3_t_r[i][j][olab_pkg::TPR_W-1:olab_pkg::RCP_SH];
        // estimate is low by at most one
        rem  = olab_pkg::QD_W'(s4_nsh_r[i][j]) - s4_qd_r[i][j];
        q    = s4_q_r[i][j] + olab_pkg::QE_W'(rem >= olab_pkg::QD_W'(olab_pkg::DIV_K));
      end

      always_ff @(posedge clk) begin
        if (en) begin
          s1_p_r[i][j]   <= olab_pkg::PROD_W'(absv) * olab_pkg::PROD_W'(coef[i][j].mag);
          s1_neg_r[i][j] <= in_vec[j][olab_pkg::FIELD_W-1] ^ coef[i][j].neg;
          s2_nsh_r[i][j] <= n[olab_pkg::PROD_W-1:olab_pkg::DIV_SH];
          s2_a_r[i][j]   <= n[olab_pkg::PROD_W-1:olab_pkg::APX_SH];
          s2_neg_r[i][j] <= s1_neg_r[i][j];
          s3_t_r[i][j]   <= olab_pkg::TPR_W'(s2_a_r[i][j]) * olab_pkg::TPR_W'(olab_pkg::RCP_K);
          s3_nsh_r[i][j] <= s2_nsh_r[i][j];
          s3_neg_r[i][j] <= s2_neg_r[i][j];
          s4_q_r[i][j]   <= qe;
          s4_qd_r[i][j]  <= olab_pkg::QD_W'(qe) * olab_pkg::QD_W'(olab_pkg::DIV_K);
          s4_nsh_r[i][j] <= s3_nsh_r[i][j];
          s4_neg_r[i][j] <= s3_neg_r[i][j];
          s5_q_r[i][j]   <= s4_neg_r[i][j] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[i] <= olab_pkg::ACC_W'(s5_q_r[i][0]) + olab_pkg::ACC_W'(s5_q_r[i][1])
                  + olab_pkg::ACC_W'(s5_q_r[i][2]);
      end
    end

    assign out_vec[i] = acc_r[i];
  end

  assign out_valid = v_r[5];

endmodule
`default_nettype wire

>>> rtl/olab_cbrt.sv
// Sign-preserving cube root, one root bit per pipeline stage, three lanes.
`default_nettype none
module olab_cbrt (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  en,
  input  wire logic                                  in_valid,
  input  wire logic signed [olab_pkg::ACC_W-1:0]     in_vec [3],
  output logic                                       out_valid,
  output logic signed [olab_pkg::FIELD_W-1:0]        out_vec [3]
);

  localparam int NST = olab_pkg::ROOT_W;
  localparam int CW  = olab_pkg::CUBE_W;

  logic [NST-1:0]        v_r;
  olab_pkg::cbrt_lane_t  st_r [NST][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam int B = NST - 1 - k;
    for (genvar l = 0; l < 3; l++) begin : g_lane
      olab_pkg::cbrt_lane_t cur;
      olab_pkg::cbrt_lane_t nxt;
      logic [CW-1:0] c3;
      logic [CW-1:0] tgt;
      logic [CW-1:0] y_e;
      logic [CW-1:0] y2_e;

      if (k == 0) begin : g_first
        logic [olab_pkg::ACC_W-1:0] amag;

        always_comb begin
          amag     = in_vec[l][olab_pkg::ACC_W-1] ? olab_pkg::ACC_W'(-in_vec[l])
                                                  : olab_pkg::ACC_W'(in_vec[l]);
          cur.neg  = in_vec[l][olab_pkg::ACC_W-1];
          cur.tmag = amag[olab_pkg::MAG_W-1:0];
          cur.y    = '0;
          cur.y2   = '0;
          cur.y3   = '0;
        end
      end else begin : g_next
        assign cur  = st_r[k-1][l];
      end

      // (y + 2^B)^3 and (y + 2^B)^2 from the running y, y^2, y^3
      always_comb begin
        y_e  = CW'(cur.y);
        y2_e = CW'(cur.y2);
        c3   = CW'(cur.y3) + ((y2_e + (y2_e << 1)) << B) + ((y_e + (y_e << 1)) << (2 * B))
             + (CW'(1) << (3 * B));
        tgt  = CW'({cur.tmag, {(2 * olab_pkg::FRAC_BITS){1'b0}}});
        nxt  = cur;
        if (c3 <= tgt) begin
          nxt.y  = cur.y | (olab_pkg::ROOT_W'(1) << B);
          nxt.y2 = (2 * olab_pkg::ROOT_W)'(y2_e + (y_e << (B + 1)) + (CW'(1) << (2 * B)));
          nxt.y3 = (3 * olab_pkg::ROOT_W)'(c3);
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          st_r[k][l] <= nxt;
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    logic signed [olab_pkg::FIELD_W-1:0] root;
    assign root = $signed(olab_pkg::FIELD_W'(st_r[NST-1][l].y));
    assign out_vec[l] = st_r[NST-1][l].neg ? -root : root;
  end

  assign out_valid = v_r[NST-1];

endmodule
`default_nettype wire

>>> rtl/linear_rgb_to_oklab.sv
// Top level: linear RGB to Oklab pipeline with output skid register.
`default_nettype none
// Converts one linear RGB pixel (signed Q4.16) to Oklab L, a, b (signed Q4.16,
// saturated). Takes one item per clock while the receiver keeps up. From input
// accept to output valid an item passes a six-stage RGB-to-LMS matrix unit, an
// eighteen-stage cube root that resolves one root bit per stage, a six-stage
// LMS-to-Lab matrix unit and the output register. A skid register behind the
// output lets the pipeline move one more item while a result waits; in_pix.ready
// drops only when both output and skid registers hold items. No state is kept
// between items.
module linear_rgb_to_oklab (
  input  wire logic        clk,
  input  wire logic        rst_n,
  olab_in_if.sink          in_pix,
  olab_out_if.source       out_lab
);

  logic                                  en;
  logic signed [olab_pkg::FIELD_W-1:0]   rgb [3];
  logic                                  lms_valid;
  logic signed [olab_pkg::ACC_W-1:0]     lms [3];
  logic                                  root_valid;
  logic signed [olab_pkg::FIELD_W-1:0]   root [3];
  logic                                  lab_valid;
  logic signed [olab_pkg::ACC_W-1:0]     lab [3];
  logic signed [olab_pkg::FIELD_W-1:0]   sat [3];
  logic                                  leave;

  logic                                  out_valid_r;
  logic signed [olab_pkg::FIELD_W-1:0]   out_r  [3];
  logic                                  skid_valid_r;
  logic signed [olab_pkg::FIELD_W-1:0]   skid_r [3];

  assign en           = !skid_valid_r;
  assign in_pix.ready = en;

  assign rgb[0] = in_pix.red_linear;
  assign rgb[1] = in_pix.green_linear;
  assign rgb[2] = in_pix.blue_linear;

  olab_matmul u_to_lms (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_pix.valid),
    .in_vec    (rgb),
    .coef      (olab_pkg::TO_LMS),
    .out_valid (lms_valid),
    .out_vec   (lms)
  );

  olab_cbrt u_cbrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (lms_valid),
    .in_vec    (lms),
    .out_valid (root_valid),
    .out_vec   (root)
  );

  olab_matmul u_to_lab (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (root_valid),
    .in_vec    (root),
    .coef      (olab_pkg::TO_LAB),
    .out_valid (lab_valid),
    .out_vec   (lab)
  );

  for (genvar i = 0; i < 3; i++) begin : g_sat
    always_comb begin
      if (lab[i] > olab_pkg::ACC_W'(olab_pkg::FIELD_MAX)) begin
        sat[i] = olab_pkg::FIELD_MAX;
      end else if (lab[i] < olab_pkg::ACC_W'(olab_pkg::FIELD_MIN)) begin
        sat[i] = olab_pkg::FIELD_MIN;
      end else begin
        sat[i] = olab_pkg::FIELD_W'(lab[i]);
      end
    end
  end

  // item leaving the last pipeline stage this cycle
  assign leave = en && lab_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_lab.ready) begin
      out_valid_r  <= skid_valid_r || leave;
      skid_valid_r <= 1'b0;
    end else if (leave) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (!out_valid_r || out_lab.ready) begin
        out_r[i] <= skid_valid_r ? skid_r[i] : sat[i];
      end else if (leave) begin
        skid_r[i] <= sat[i];
      end
    end
  end

  assign out_lab.valid            = out_valid_r;
  assign out_lab.lightness        = out_r[0];
  assign out_lab.green_red_axis   = out_r[1];
  assign out_lab.blue_yellow_axis = out_r[2];

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output register is empty");

  a_stall_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_lab.ready) |=> (out_valid_r && $stable(out_r[0])))
    else $error("stalled output item changed or dropped");

  a_no_leave_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_lab.ready) |=> skid_valid_r)
    else $error("skid item lost under stall");
`endif

endmodule
`default_nettype wire

>>> sim/linear_rgb_to_oklab_test.sv
// Self-checking testbench for the linear RGB to Oklab converter.
`timescale 1ns / 100ps
`default_nettype none
module linear_rgb_to_oklab_test;

  typedef logic signed [olab_pkg::FIELD_W-1:0] chan_t;
  typedef struct packed {
    chan_t l;
    chan_t a;
    chan_t b;
  } lab_t;
  typedef struct {
    chan_t r;
    chan_t g;
    chan_t b;
    bit    known;
    lab_t  lab;
  } pixel_row_t;

  localparam longint SCALE = 64'sd10000000000;
  localparam longint HALF  = 64'sd5000000000;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_DIRECTED = 19;

  // Published 10-digit coefficients, scaled by 10^10
  localparam longint RGB_TO_CONE [9] = '{
    64'sd4122214708, 64'sd5363325363, 64'sd514459929,
    64'sd2119034982, 64'sd6806995451, 64'sd1073969566,
    64'sd883024619,  64'sd2817188376, 64'sd6299787005};
  localparam longint CONE_TO_LAB [9] = '{
    64'sd2104542553,  64'sd7936177850,   -64'sd40720468,
    64'sd19779984951, -64'sd24285922050, 64'sd4505937099,
    64'sd259040371,   64'sd7827717662,   -64'sd8086757660};

  logic clk;
  logic rst_n;
  olab_in_if  in_pix ();
  olab_out_if out_lab ();

  linear_rgb_to_oklab i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_lab (out_lab)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  lab_t lab_pending[$];
  int   errors;
  int   pixels_in;
  int   pixels_out;
  int   idle_pct;
  int   stall_pct;
  int   hold_requests;
  int   idle_cycles;

  function automatic longint scaled(longint v, longint k);
    longint p, m, q;
    p = v * k;
    m = (p < 0) ? -p : p;
    q = (m + HALF) / SCALE;
    return (p < 0) ? -q : q;
  endfunction

  // Floor cube root of |x| * 2^32, sign of x restored
  function automatic longint signed_root(longint x);
    logic [127:0] tgt, y, cand;
    longint mag;
    mag = (x < 0) ? -x : x;
    tgt = 128'(mag) << (2 * olab_pkg::FRAC_BITS);
    y = '0;
    for (int bit_i = 25; bit_i >= 0; bit_i--) begin
      cand = y | (128'd1 << bit_i);
      if (cand * cand * cand <= tgt) y = cand;
    end
    return (x < 0) ? -longint'(y) : longint'(y);
  endfunction

  function automatic chan_t clamp(longint v);
    if (v > 64'sd524287) return olab_pkg::FIELD_MAX;
    if (v < -64'sd524288) return olab_pkg::FIELD_MIN;
    return chan_t'(v);
  endfunction

  function automatic lab_t oklab_of(chan_t r, chan_t g, chan_t b);
    longint rgb[3], cone[3], acc;
    chan_t res[3];
    rgb = '{longint'(r), longint'(g), longint'(b)};
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += scaled(rgb[j], RGB_TO_CONE[3*i+j]);
      cone[i] = signed_root(acc);
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += scaled(cone[j], CONE_TO_LAB[3*i+j]);
      res[i] = clamp(acc);
    end
    return '{res[0], res[1], res[2]};
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH %s", msg);
    errors++;
  endtask

  // Accept and check at the rising edge
  always @(posedge clk) begin
    lab_t want;
    if (rst_n) begin
      if (in_pix.valid && in_pix.ready) begin
        lab_pending.push_back(oklab_of(in_pix.red_linear, in_pix.green_linear,
                                       in_pix.blue_linear));
        pixels_in++;
      end
      if (out_lab.valid && out_lab.ready) begin
        if (lab_pending.size() == 0) begin
          report_mismatch("result with no pixel outstanding");
        end else begin
          want = lab_pending.pop_front();
          if (out_lab.lightness !== want.l)
            report_mismatch($sformatf("item %0d L: got %0d expected %0d",
                                      pixels_out, out_lab.lightness, want.l));
          if (out_lab.green_red_axis !== want.a)
            report_mismatch($sformatf("item %0d a: got %0d expected %0d",
                                      pixels_out, out_lab.green_red_axis, want.a));
          if (out_lab.blue_yellow_axis !== want.b)
            report_mismatch($sformatf("item %0d b: got %0d expected %0d",
                                      pixels_out, out_lab.blue_yellow_axis, want.b));
        end
        pixels_out++;
      end
      if ((in_pix.valid && in_pix.ready) || (out_lab.valid && out_lab.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  initial begin
    int hold_cnt;
    int served;
    hold_cnt = 0;
    served = 0;
    out_lab.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (served < hold_requests) begin
        served++;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_lab.ready <= 1'b0;
      end else begin
        out_lab.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_pixel(chan_t r, chan_t g, chan_t b);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_pix.valid <= 1'b0;
      @(negedge clk);
    end
    in_pix.valid        <= 1'b1;
    in_pix.red_linear   <= r;
    in_pix.green_linear <= g;
    in_pix.blue_linear  <= b;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
  endtask

  function automatic chan_t pick_channel();
    case ($urandom_range(4))
      0: return chan_t'($urandom);
      1: return chan_t'($urandom_range(65536));
      2: return chan_t'(int'($urandom_range(64)) - 32);
      3: return ($urandom_range(1)) ? olab_pkg::FIELD_MAX : olab_pkg::FIELD_MIN;
      default: return chan_t'(int'($urandom_range(131072)) - 65536);
    endcase
  endfunction

  pixel_row_t directed [N_DIRECTED] = '{
    '{20'sd0, 20'sd0, 20'sd0, 1'b1, '{20'sd0, 20'sd0, 20'sd0}},
    '{20'sd65536, 20'sd65536, 20'sd65536, 1'b0, '0},
    '{20'sd65536, 20'sd0, 20'sd0, 1'b0, '0},
    '{20'sd0, 20'sd65536, 20'sd0, 1'b0, '0},
    '{20'sd0, 20'sd0, 20'sd65536, 1'b0, '0},
    '{olab_pkg::FIELD_MAX, olab_pkg::FIELD_MAX, olab_pkg::FIELD_MAX, 1'b0, '0},
    '{olab_pkg::FIELD_MIN, olab_pkg::FIELD_MIN, olab_pkg::FIELD_MIN, 1'b0, '0},
    '{olab_pkg::FIELD_MAX, olab_pkg::FIELD_MIN, olab_pkg::FIELD_MAX, 1'b0, '0},
    '{olab_pkg::FIELD_MIN, olab_pkg::FIELD_MAX, olab_pkg::FIELD_MIN, 1'b0, '0},
    '{olab_pkg::FIELD_MAX, 20'sd0, 20'sd0, 1'b0, '0},
    '{20'sd0, olab_pkg::FIELD_MIN, 20'sd0, 1'b0, '0},
    '{20'sd0, 20'sd0, olab_pkg::FIELD_MAX, 1'b0, '0},
    '{20'sd1, 20'sd1, 20'sd1, 1'b0, '0},
    '{-20'sd1, -20'sd1, -20'sd1, 1'b0, '0},
    '{20'sd1, 20'sd0, 20'sd0, 1'b0, '0},
    '{20'sd0, 20'sd0, -20'sd1, 1'b0, '0},
    '{-20'sd65536, 20'sd65536, -20'sd65536, 1'b0, '0},
    '{20'sd32768, 20'sd32768, 20'sd32768, 1'b0, '0},
    '{20'sd200000, -20'sd100000, 20'sd50000, 1'b0, '0}
  };

  initial begin
    lab_t got_direct;
    errors = 0;
    pixels_in = 0;
    pixels_out = 0;
    idle_cycles = 0;
    hold_requests = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_pix.valid = 1'b0;
    in_pix.red_linear = '0;
    in_pix.green_linear = '0;
    in_pix.blue_linear = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].known) begin
        got_direct = oklab_of(directed[i].r, directed[i].g, directed[i].b);
        if (got_direct !== directed[i].lab)
          report_mismatch($sformatf("predictor disagrees on directed row %0d", i));
      end
      send_pixel(directed[i].r, directed[i].g, directed[i].b);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      // Fill the pipeline against a blocked receiver
      if (phase == 0) hold_requests++;
      for (int n = 0; n < 400; n++) begin
        send_pixel(pick_channel(), pick_channel(), pick_channel());
      end
    end
    @(negedge clk);
    in_pix.valid <= 1'b0;

    while (lab_pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Converted %0d pixels, checked %0d results over four idle/stall mixes",
             pixels_in, pixels_out);
    $display("Covered field extremes, zero, unit colors and a long output hold-off");
    if (errors == 0 && lab_pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
